FILE: src/deq_pkg.sv
// shared constants, opcodes and item types of the double-ended queue
package deq_pkg;

  // queue geometry
  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int CountW    = $clog2(Depth + 1);

  // opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // request item
  typedef struct packed {
    logic [2:0]           opcode;
    logic [DataWidth-1:0] item_data;
  } deq_req_t;

  // result item
  typedef struct packed {
    logic [1:0]           status;
    logic [DataWidth-1:0] popped_data;
    logic [CountW-1:0]    entry_count;
    logic [DataWidth-1:0] front_data;
    logic [DataWidth-1:0] back_data;
  } deq_rsp_t;

  // per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } deq_ctrl_t;

endpackage

FILE: src/deq_cell.sv
// one storage cell of the queue chain: holds one word and its valid flag
module deq_cell import deq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  deq_ctrl_t            ctrl,
  input  logic [DataWidth-1:0] item,
  input  logic                 prev_valid,
  input  logic [DataWidth-1:0] prev_data,
  input  logic                 nbr_valid,
  input  logic [DataWidth-1:0] nbr_data,
  output logic                 valid,
  output logic [DataWidth-1:0] data,
  output logic                 valid_next,
  output logic [DataWidth-1:0] data_next
);

  // next contents: clear, shift towards the back, shift towards the front, or edit in place
  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (ctrl.clear) begin
      valid_next = 1'b0;
    end else if (ctrl.push_front) begin
      valid_next = prev_valid;
      data_next  = prev_data;
    end else if (ctrl.pop_front) begin
      valid_next = nbr_valid;
      data_next  = nbr_data;
    end else if (ctrl.push_back) begin
      if (prev_valid && !valid) begin
        valid_next = 1'b1;
        data_next  = item;
      end
    end else if (ctrl.pop_back) begin
      if (valid && !nbr_valid) begin
        valid_next = 1'b0;
      end
    end
  end

  // valid flag is control state, the word needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: src/double_ended_queue_core.sv
// top level of the double-ended queue: cell chain, entry counter and result register
//
// Usage: a request item (opcode, item_data) enters on req_valid/req_stall and
// one result item (status, popped_data, entry_count, front_data, back_data)
// leaves on rsp_valid/rsp_stall for every request.
// The queue is a row of Depth cells with cell 0 at the front. Pushes and pops
// at the front shift the whole row by one place; pushes and pops at the back
// touch only the cell at the boundary of the filled part.
// The result is registered and appears the cycle after the request is
// accepted. One request is taken per cycle while no result is held back,
// set by the cell update and the result register.
// When the receiver stalls, the held result stays put and req_stall rises
// until that result is taken, so no result is lost or repeated.
// Reset empties the queue (all cell valid flags and the entry count clear)
// and drops any pending result; the stored words are not cleared.
// Rejected pushes (full) and pops (empty) leave the queue unchanged.
module double_ended_queue_core import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  deq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output deq_rsp_t rsp
);

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic [CountW-1:0]    count;
  logic [CountW-1:0]    count_next;
  deq_ctrl_t            ctrl;
  logic [1:0]           status;
  logic [DataWidth-1:0] popped;
  logic [DataWidth-1:0] back_cur;
  logic [DataWidth-1:0] back_new;
  logic [DataWidth-1:0] front_new;

  logic                 cell_valid [Depth];
  logic [DataWidth-1:0] cell_data  [Depth];
  logic                 cell_vnext [Depth];
  logic [DataWidth-1:0] cell_dnext [Depth];
  logic                 prev_valid [Depth];
  logic [DataWidth-1:0] prev_data  [Depth];
  logic                 nbr_valid  [Depth];
  logic [DataWidth-1:0] nbr_data   [Depth];
  logic                 last_cur   [Depth];
  logic                 last_new   [Depth];

  // handshake: a new item enters unless a result is held back by the receiver
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CountW'(Depth));
  assign is_empty  = (count == '0);

  // decode the opcode into chain commands and a status
  always_comb begin
    ctrl   = '0;
    status = ST_OK;
    case (req.opcode)
      OP_PUSH_FRONT: begin
        if (is_full) status = ST_FULL;
        else ctrl.push_front = accept;
      end
      OP_PUSH_BACK: begin
        if (is_full) status = ST_FULL;
        else ctrl.push_back = accept;
      end
      OP_POP_FRONT: begin
        if (is_empty) status = ST_EMPTY;
        else ctrl.pop_front = accept;
      end
      OP_POP_BACK: begin
        if (is_empty) status = ST_EMPTY;
        else ctrl.pop_back = accept;
      end
      OP_CLEAR: begin
        ctrl.clear = accept;
      end
      OP_QUERY: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // neighbour wiring: the front cell sees the pushed word ahead of it
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (i == 0) begin
        prev_valid[i] = 1'b1;
        prev_data[i]  = req.item_data;
      end else begin
        prev_valid[i] = cell_valid[i-1];
        prev_data[i]  = cell_data[i-1];
      end
      if (i == Depth - 1) begin
        nbr_valid[i] = 1'b0;
        nbr_data[i]  = '0;
      end else begin
        nbr_valid[i] = cell_valid[i+1];
        nbr_data[i]  = cell_data[i+1];
      end
    end
  end

  // the row of cells
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .item       (req.item_data),
      .prev_valid (prev_valid[g]),
      .prev_data  (prev_data[g]),
      .nbr_valid  (nbr_valid[g]),
      .nbr_data   (nbr_data[g]),
      .valid      (cell_valid[g]),
      .data       (cell_data[g]),
      .valid_next (cell_vnext[g]),
      .data_next  (cell_dnext[g])
    );
  end

  // back of queue: the one valid cell whose neighbour is empty, before and after
  always_comb begin
    back_cur = '0;
    back_new = '0;
    for (int i = 0; i < Depth; i++) begin
      if (i == Depth - 1) begin
        last_cur[i] = cell_valid[i];
        last_new[i] = cell_vnext[i];
      end else begin
        last_cur[i] = cell_valid[i] && !cell_valid[i+1];
        last_new[i] = cell_vnext[i] && !cell_vnext[i+1];
      end
      back_cur = back_cur | (cell_data[i] & {DataWidth{last_cur[i]}});
      back_new = back_new | (cell_dnext[i] & {DataWidth{last_new[i]}});
    end
  end

  assign front_new = cell_vnext[0] ? cell_dnext[0] : '0;

  // word removed by a successful pop
  always_comb begin
    popped = '0;
    if (ctrl.pop_front) popped = cell_data[0];
    else if (ctrl.pop_back) popped = back_cur;
  end

  // entry counter
  always_comb begin
    count_next = count;
    if (ctrl.clear) count_next = '0;
    else if (ctrl.push_front || ctrl.push_back) count_next = count + CountW'(1);
    else if (ctrl.pop_front || ctrl.pop_back) count_next = count - CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status;
      rsp.popped_data <= popped;
      rsp.entry_count <= count_next;
      rsp.front_data  <= front_new;
      rsp.back_data   <= back_new;
    end
  end

endmodule

FILE: dv/double_ended_queue_core_tb.sv
// self-checking testbench for the double-ended queue core with random idling on both sides
module double_ended_queue_core_tb;
  import deq_pkg::*;

  // opcodes outside the defined set, handled as a query
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RandomItems = 1350;
  localparam int StuckLimit  = 1000;
  localparam int LongHold    = 120;
  localparam int MaxPrinted  = 60;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  deq_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  deq_rsp_t rsp;

  double_ended_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  deq_req_t pending_req[$];
  deq_rsp_t awaited_results[$];
  int       mismatch_count = 0;

  // shadow copy of the queue contents
  logic [DataWidth-1:0] ring_word [Depth];
  int                   head_pos   = 0;
  int                   fill_count = 0;

  // apply one operation to the shadow queue and return the result it should give
  function automatic deq_rsp_t next_deq_result(deq_req_t r);
    deq_rsp_t res;
    int       pos;
    res = '0;
    res.status = ST_OK;
    case (r.opcode)
      OP_PUSH_FRONT: begin
        if (fill_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          head_pos = (head_pos + Depth - 1) % Depth;
          ring_word[head_pos] = r.item_data;
          fill_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          pos = (head_pos + fill_count) % Depth;
          ring_word[pos] = r.item_data;
          fill_count++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_data = ring_word[head_pos];
          head_pos = (head_pos + 1) % Depth;
          fill_count--;
        end
      end
      OP_POP_BACK: begin
        if (fill_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = (head_pos + fill_count - 1) % Depth;
          res.popped_data = ring_word[pos];
          fill_count--;
        end
      end
      OP_CLEAR: begin
        fill_count = 0;
        head_pos   = 0;
      end
      default: ;
    endcase
    res.entry_count = fill_count[CountW-1:0];
    if (fill_count != 0) begin
      res.front_data = ring_word[head_pos];
      res.back_data  = ring_word[(head_pos + fill_count - 1) % Depth];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxPrinted) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // idle length: mostly none, some short, a few long, with calm stretches of none
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(20, 80);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [2:0] op, logic [DataWidth-1:0] data);
    deq_req_t r;
    r.opcode    = op;
    r.item_data = data;
    pending_req.push_back(r);
  endtask

  // sender: offers pending items, holds each until taken, predicts on acceptance
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      if (req_valid && !req_stall) awaited_results.push_back(next_deq_result(req));
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          req       <= pending_req.pop_front();
          req_valid <= 1'b1;
          send_gap  = pick_idle(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each taken result and drives random stalls plus long hold-offs
  int       stall_left = 0;
  int       recv_calm  = 0;
  int       hold_left  = 0;
  int       rsp_seen   = 0;
  deq_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none awaited", rsp_seen));
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      rsp_seen, rsp.status, want.status));
          if (rsp.popped_data !== want.popped_data)
            report_mismatch($sformatf("result %0d popped_data %h, expected %h",
                                      rsp_seen, rsp.popped_data, want.popped_data));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                      rsp_seen, rsp.entry_count, want.entry_count));
          if (rsp.front_data !== want.front_data)
            report_mismatch($sformatf("result %0d front_data %h, expected %h",
                                      rsp_seen, rsp.front_data, want.front_data));
          if (rsp.back_data !== want.back_data)
            report_mismatch($sformatf("result %0d back_data %h, expected %h",
                                      rsp_seen, rsp.back_data, want.back_data));
        end
        rsp_seen++;
        if (rsp_seen == 200 || rsp_seen == 900) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall  <= 1'b0;
        stall_left = pick_idle(recv_calm);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("timeout: no item moved for %0d cycles", StuckLimit);
          $display("double_ended_queue_core_tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int         trend;
    int         phase_left;
    int         push_weight;
    int         r;
    logic [2:0] op;

    // directed: empty pops, extreme words, queries, fill to full, full pushes, clear
    add_item(OP_POP_FRONT, '1);
    add_item(OP_POP_BACK, '1);
    add_item(OP_PUSH_FRONT, '1);
    add_item(OP_PUSH_BACK, '0);
    add_item(OP_QUERY, '1);
    add_item(OP_SPARE_A, pick_word());
    add_item(OP_SPARE_B, '1);
    for (int i = 0; i < Depth - 2; i++)
      add_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    add_item(OP_PUSH_FRONT, '1);
    add_item(OP_PUSH_BACK, '1);
    add_item(OP_POP_FRONT, '0);
    add_item(OP_POP_BACK, '0);
    add_item(OP_CLEAR, '1);
    add_item(OP_POP_FRONT, '0);

    // random: phases that lean towards growing, shrinking or neither
    phase_left = 0;
    trend      = 0;
    for (int i = 0; i < RandomItems; i++) begin
      if (phase_left == 0) begin
        trend      = $urandom_range(0, 2);
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      push_weight = (trend == 0) ? 80 : (trend == 1) ? 20 : 50;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_CLEAR;
      end else if (r < 8) begin
        case ($urandom_range(0, 2))
          0:       op = OP_QUERY;
          1:       op = OP_SPARE_A;
          default: op = OP_SPARE_B;
        endcase
      end else if ($urandom_range(0, 99) < push_weight) begin
        op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
      end
      add_item(op, pick_word());
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // drain, then give any stray result time to show up
    while (pending_req.size() != 0 || req_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("double_ended_queue_core_tb passed");
    end else begin
      $display("double_ended_queue_core_tb failed");
    end
    $finish;
  end

endmodule
